// ----- sv/deq_pkg.sv -----
// Package for the double-ended queue: payload structs, command and status
// codes, internal operation type and default sizes.
// No dependencies.
package deq_pkg;

    localparam int DEFAULT_CAPACITY   = 16;
    localparam int DEFAULT_VALUE_BITS = 32;
    localparam int QUEUE_DEPTH        = 2;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    // command codes carried by an input item
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic signed [31:0] item_value;
    } request_t;

    typedef struct packed {
        logic signed [31:0]    result_value;
        logic [STATUS_W-1:0]   status;
        logic                  last_of_run;
    } result_t;

    // decoded operation handed from the front end to the back end
    typedef enum logic [2:0] {
        KIND_PUSH_FRONT,
        KIND_PUSH_BACK,
        KIND_POP_FRONT,
        KIND_POP_BACK,
        KIND_DUMP
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [31:0] value;
    } op_t;

endpackage

// ----- sv/deq_front.sv -----
// Front end: takes items off the command port, decodes the command and
// drops unknown codes. Depends on deq_pkg.
module deq_front (
    input  logic              start,
    output logic              busy,
    input  deq_pkg::request_t request,
    input  logic              q_full,
    output logic              q_push,
    output deq_pkg::op_t      q_op
);

    logic known;

    always_comb
    begin
        known         = 1'b1;
        q_op.value    = request.item_value;
        q_op.kind     = deq_pkg::KIND_DUMP;
        unique case (request.command)
            deq_pkg::CMD_PUSH_FRONT: q_op.kind = deq_pkg::KIND_PUSH_FRONT;
            deq_pkg::CMD_PUSH_BACK:  q_op.kind = deq_pkg::KIND_PUSH_BACK;
            deq_pkg::CMD_POP_FRONT:  q_op.kind = deq_pkg::KIND_POP_FRONT;
            deq_pkg::CMD_POP_BACK:   q_op.kind = deq_pkg::KIND_POP_BACK;
            deq_pkg::CMD_DUMP:       q_op.kind = deq_pkg::KIND_DUMP;
            default:                 known     = 1'b0;
        endcase
    end

    assign busy   = q_full;
    // unknown commands are taken but never reach the back end
    assign q_push = start && !q_full && known;

endmodule

// ----- sv/deq_queue.sv -----
// Small op queue between the front and back ends.
// Depends on deq_pkg.
module deq_queue #(
    parameter int DEPTH = deq_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  deq_pkg::op_t push_op,
    output logic         full,
    input  logic         pop,
    output logic         valid,
    output deq_pkg::op_t head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    deq_pkg::op_t     slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ----- sv/deq_back.sv -----
// Back end: ring store with front index and count, executes one op per
// cycle while not dumping and walks the store for a dump. Depends on deq_pkg.
module deq_back #(
    parameter int CAPACITY   = deq_pkg::DEFAULT_CAPACITY,
    parameter int VALUE_BITS = deq_pkg::DEFAULT_VALUE_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             op_valid,
    input  deq_pkg::op_t     op,
    output logic             op_pop,
    output logic             done,
    output deq_pkg::result_t result
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = IDX_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } state_t;

    logic signed [VALUE_BITS-1:0] store_mem [CAPACITY];

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] dump_ptr_reg, dump_ptr_next;
    logic [CNT_W-1:0] dump_rem_reg, dump_rem_next;
    logic             done_reg, done_next;

    logic [deq_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                         last_reg, last_next;
    logic signed [31:0]           echo_reg, echo_next;
    logic                         use_rd_reg, use_rd_next;
    logic signed [VALUE_BITS-1:0] rd_data_reg;

    logic                         wr_en, rd_en;
    logic [IDX_W-1:0]             wr_addr, rd_addr;
    logic signed [VALUE_BITS-1:0] wr_data;
    logic [SUM_W-1:0]             tail_sum;
    logic [IDX_W-1:0]             tail_idx, last_idx;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(CAPACITY - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(CAPACITY - 1) : i - 1'b1;
    endfunction

    // slot after the back value, and the back value itself
    assign tail_sum = {1'b0, front_reg} + SUM_W'(count_reg);
    assign tail_idx = (tail_sum >= SUM_W'(CAPACITY)) ?
                      IDX_W'(tail_sum - SUM_W'(CAPACITY)) : IDX_W'(tail_sum);
    assign last_idx = idx_dec(tail_idx);

    assign op_pop = op_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        front_next    = front_reg;
        count_next    = count_reg;
        dump_ptr_next = dump_ptr_reg;
        dump_rem_next = dump_rem_reg;
        done_next     = 1'b0;
        status_next   = deq_pkg::STATUS_OK;
        last_next     = 1'b1;
        echo_next     = '0;
        use_rd_next   = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = tail_idx;
        wr_data       = VALUE_BITS'(op.value);
        rd_en         = 1'b0;
        rd_addr       = front_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (op_valid)
                begin
                    done_next = 1'b1;
                    unique case (op.kind)
                        deq_pkg::KIND_PUSH_FRONT,
                        deq_pkg::KIND_PUSH_BACK:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                status_next = deq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                                echo_next  = 32'(wr_data);
                                if (op.kind == deq_pkg::KIND_PUSH_FRONT)
                                begin
                                    wr_addr    = idx_dec(front_reg);
                                    front_next = idx_dec(front_reg);
                                end
                            end
                        end
                        deq_pkg::KIND_POP_FRONT,
                        deq_pkg::KIND_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = deq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                rd_en       = 1'b1;
                                use_rd_next = 1'b1;
                                count_next  = count_reg - 1'b1;
                                if (op.kind == deq_pkg::KIND_POP_FRONT)
                                begin
                                    front_next = idx_inc(front_reg);
                                end
                                else
                                begin
                                    rd_addr = last_idx;
                                end
                            end
                        end
                        deq_pkg::KIND_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = deq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                rd_en       = 1'b1;
                                use_rd_next = 1'b1;
                                last_next   = (count_reg == CNT_W'(1));
                                if (count_reg != CNT_W'(1))
                                begin
                                    state_next    = ST_DUMP;
                                    dump_ptr_next = idx_inc(front_reg);
                                    dump_rem_next = count_reg - 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            done_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                done_next     = 1'b1;
                rd_en         = 1'b1;
                use_rd_next   = 1'b1;
                rd_addr       = dump_ptr_reg;
                last_next     = (dump_rem_reg == CNT_W'(1));
                dump_ptr_next = idx_inc(dump_ptr_reg);
                dump_rem_next = dump_rem_reg - 1'b1;
                if (dump_rem_reg == CNT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            front_reg    <= '0;
            count_reg    <= '0;
            dump_ptr_reg <= '0;
            dump_rem_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            front_reg    <= front_next;
            count_reg    <= count_next;
            dump_ptr_reg <= dump_ptr_next;
            dump_rem_reg <= dump_rem_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        last_reg   <= last_next;
        echo_reg   <= echo_next;
        use_rd_reg <= use_rd_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign done                = done_reg;
    assign result.result_value = use_rd_reg ? 32'(rd_data_reg) : echo_reg;
    assign result.status       = status_reg;
    assign result.last_of_run  = last_reg;

endmodule

// ----- sv/double_ended_queue.sv -----
// Top level of the bounded double-ended queue: front end, op queue and
// back end. Depends on deq_pkg, deq_front, deq_queue and deq_back.
//
//   port     dir  type       meaning
//   start    in   logic      item offered; taken when busy is low
//   busy     out  logic      op queue full, items are held off
//   request  in   request_t  command and item_value
//   done     out  logic      one-cycle strobe, result valid this cycle
//   result   out  result_t   result_value, status, last_of_run
//
// Push and pop: one item per cycle while busy is low; the item passes the
// op queue, then the registered store read, and the result strobe is raised
// with the result that is registered there.
// Dump: one result per held entry, one per cycle, set by the single read
// port of the ring store; the op queue fills behind it and raises busy.
// Unknown commands are taken and give no result.
// Reset clears indices, count and control; the store needs no clearing.
// The receiver cannot stall: each result is on the ports for one cycle.
module double_ended_queue #(
    parameter int CAPACITY   = deq_pkg::DEFAULT_CAPACITY,
    parameter int VALUE_BITS = deq_pkg::DEFAULT_VALUE_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  deq_pkg::request_t request,
    output logic              done,
    output deq_pkg::result_t  result
);

    logic         q_full, q_push, q_valid, q_pop;
    deq_pkg::op_t q_in_op, q_head;

    // decode and drop unknown commands
    deq_front u_front (
        .start   (start),
        .busy    (busy),
        .request (request),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_op    (q_in_op)
    );

    // decouples intake from a long dump
    deq_queue #(
        .DEPTH (deq_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_in_op),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .head    (q_head)
    );

    // ring store, indices and result registers
    deq_back #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (q_valid),
        .op       (q_head),
        .op_pop   (q_pop),
        .done     (done),
        .result   (result)
    );

endmodule
